// ===== rtl/kcr_pkg.sv =====
// ----------------------------------------------------------------------------
// kcr_pkg: shared types and constants of the key chord remapper
// Holds the beat payload types, the job record between the front and back
// parts, the register map and the key event codes.
// ----------------------------------------------------------------------------
package kcr_pkg;

    // Key event codes and register reset values.
    localparam logic [15:0] EV_KEY        = 16'd1;
    localparam logic [15:0] CODE_SPACE    = 16'd57;
    localparam logic [9:0]  CODE_RALT     = 10'd100;
    localparam logic [9:0]  TARGET_RESET  = 10'd40;

    // Key event values.
    localparam logic [31:0] VAL_RELEASE   = 32'd0;
    localparam logic [31:0] VAL_PRESS     = 32'd1;
    localparam logic [31:0] VAL_HOLD      = 32'd2;

    // Most beats per input item, the queue depth and the sizes that follow.
    localparam int MAX_BEATS   = 4;
    localparam int SLOT_W      = $clog2(MAX_BEATS);
    localparam int CNT_W       = $clog2(MAX_BEATS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register map: register index is the word address.
    localparam int PADDR_W = 3;
    typedef enum logic {
        REG_MODIFIER = 1'b0,
        REG_TARGET   = 1'b1
    } kcr_reg_t;

    // Input beat.
    typedef struct packed {
        logic [15:0]        event_type;
        logic [15:0]        event_code;
        logic signed [31:0] event_value;
        logic signed [63:0] time_seconds;
        logic [19:0]        time_micros;
    } kcr_in_t;

    // Result beat.
    typedef struct packed {
        logic [15:0]        out_type;
        logic [15:0]        out_code;
        logic signed [31:0] out_value;
        logic signed [63:0] out_seconds;
        logic [19:0]        out_micros;
        logic               last;
    } kcr_out_t;

    // One classified item: the shared header and its list of events.
    typedef struct packed {
        logic [15:0]                 ev_type;
        logic [63:0]                 seconds;
        logic [19:0]                 micros;
        logic [CNT_W-1:0]            beats;
        logic [MAX_BEATS-1:0][15:0]  code;
        logic [MAX_BEATS-1:0][31:0]  value;
    } kcr_job_t;

    // Chord tracking flags.
    typedef struct packed {
        logic space_grabbed;
        logic modifier_grabbed;
        logic modifier_with_other;
        logic space_with_other;
        logic chord_active;
    } kcr_flags_t;

endpackage

// ===== rtl/key_chord_remapper.sv =====
// ----------------------------------------------------------------------------
// key_chord_remapper: modifier plus space chord remapper
// Filters key events and turns a held modifier plus space chord into a
// configured target key.
// ----------------------------------------------------------------------------
// Usage:
// Input events arrive on the s_ channel, one event per beat. Each accepted
// beat yields zero to four result beats on the m_ channel, in order, all with
// the input's type and timestamp; the final one carries last.
// The classifier takes one beat per cycle while the two-entry job queue has
// room. The sequencer sends one result beat per cycle while m_ready is high,
// one beat per event of the item; an item that yields no event is accepted
// and gives nothing at the output. Sustained rate is thus set by the
// sequencer, which sends each emitted event as its own beat.
// The first result beat is offered once its job has passed through the queue
// and been loaded into the sequencer's entry register.
// When the receiver holds m_ready low, the current beat stays on the port;
// the queue fills and then s_ready drops.
// Reset clears the chord state, the queue and the sequencer, and sets
// modifier_key to 100 and target_key to 40. Both registers sit on the APB
// port at byte addresses 0 and 4 and should be written while idle.
// ----------------------------------------------------------------------------
module key_chord_remapper (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  kcr_pkg::kcr_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output kcr_pkg::kcr_out_t           m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kcr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import kcr_pkg::*;

    logic [9:0] modifier_key_reg;
    logic [9:0] target_key_reg;
    kcr_reg_t   reg_sel;
    logic       cfg_write;

    logic     fq_valid, fq_ready, qb_valid, qb_ready;
    kcr_job_t fq_job, qb_job;

    // Register decode.
    assign pready    = 1'b1;
    assign reg_sel   = kcr_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_sel)
            REG_MODIFIER: prdata = {22'b0, modifier_key_reg};
            REG_TARGET:   prdata = {22'b0, target_key_reg};
            default:      prdata = '0;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modifier_key_reg <= CODE_RALT;
            target_key_reg   <= TARGET_RESET;
        end else if (cfg_write) begin
            if (reg_sel == REG_MODIFIER) begin
                modifier_key_reg <= pwdata[9:0];
            end else begin
                target_key_reg <= pwdata[9:0];
            end
        end
    end

    // Classifier.
    kcr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .modifier_key (modifier_key_reg),
        .target_key   (target_key_reg),
        .job_valid    (fq_valid),
        .job_ready    (fq_ready),
        .job          (fq_job)
    );

    // Job queue.
    kcr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    // Event sequencer.
    kcr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== rtl/kcr_front.sv =====
// ----------------------------------------------------------------------------
// kcr_front: event classifier
// Accepts input beats, tracks the chord state and turns each item into a job
// of zero to four events for the back part.
// ----------------------------------------------------------------------------
module kcr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  kcr_pkg::kcr_in_t  s_data,
    input  logic [9:0]        modifier_key,
    input  logic [9:0]        target_key,
    output logic              job_valid,
    input  logic              job_ready,
    output kcr_pkg::kcr_job_t job
);
    import kcr_pkg::*;

    kcr_flags_t  flags_reg, flags_next;
    logic [15:0] pending_reg, pending_next;

    logic [CNT_W-1:0]           n;
    logic [MAX_BEATS-1:0][15:0] codes;
    logic [MAX_BEATS-1:0][31:0] vals;
    logic [15:0] code, mod16, tgt16;
    logic [31:0] val;
    logic        is_key, is_sp, is_mod;
    logic        accept;

    assign code   = s_data.event_code;
    assign val    = s_data.event_value;
    assign mod16  = {6'b0, modifier_key};
    assign tgt16  = {6'b0, target_key};
    assign is_key = (s_data.event_type == EV_KEY);
    assign is_sp  = (code == CODE_SPACE);
    assign is_mod = (code == mod16);

    // Classify the item and build its event list.
    always_comb begin
        flags_next   = flags_reg;
        pending_next = pending_reg;
        n            = '0;
        codes        = '0;
        vals         = '0;
        if (is_key && (is_sp || is_mod)) begin
            if (!flags_reg.space_grabbed && is_sp && val == VAL_PRESS) begin
                // First space press is held back; it may complete the chord.
                flags_next.space_grabbed = 1'b1;
                if (flags_reg.modifier_grabbed) begin
                    flags_next.chord_active = 1'b1;
                    if (flags_reg.modifier_with_other) begin
                        codes[n[SLOT_W-1:0]] = mod16; vals[n[SLOT_W-1:0]] = VAL_RELEASE;
                        n = n + 1'b1;
                    end
                    codes[n[SLOT_W-1:0]] = tgt16; vals[n[SLOT_W-1:0]] = VAL_PRESS;
                    n = n + 1'b1;
                    codes[n[SLOT_W-1:0]] = tgt16; vals[n[SLOT_W-1:0]] = VAL_HOLD;
                    n = n + 1'b1;
                    if (flags_reg.modifier_with_other) begin
                        codes[n[SLOT_W-1:0]] = pending_reg;
                        vals[n[SLOT_W-1:0]]  = VAL_PRESS;
                        n = n + 1'b1;
                    end
                end
            end else if (!flags_reg.modifier_grabbed && is_mod && val == VAL_PRESS) begin
                // First modifier press is held back.
                flags_next.modifier_grabbed = 1'b1;
                if (flags_reg.space_grabbed) begin
                    flags_next.chord_active = 1'b1;
                    codes[0] = tgt16; vals[0] = VAL_PRESS;
                    codes[1] = tgt16; vals[1] = VAL_HOLD;
                    n = CNT_W'(2);
                end
            end else if (flags_reg.space_grabbed && flags_reg.modifier_grabbed
                         && val == VAL_HOLD) begin
                // Autorepeat while both are held.
                codes[0] = flags_reg.modifier_with_other ? pending_reg : tgt16;
                vals[0]  = VAL_HOLD;
                n = CNT_W'(1);
            end else if (val == VAL_HOLD) begin
                codes[0] = code; vals[0] = VAL_PRESS;
                codes[1] = code; vals[1] = VAL_HOLD;
                n = CNT_W'(2);
            end else if (val == VAL_RELEASE) begin
                if (flags_reg.chord_active) begin
                    // Releasing either half of the chord releases the target.
                    codes[n[SLOT_W-1:0]] = tgt16; vals[n[SLOT_W-1:0]] = VAL_RELEASE;
                    n = n + 1'b1;
                    if (is_sp) begin
                        flags_next.space_grabbed = 1'b0;
                        if (flags_reg.space_with_other) begin
                            codes[n[SLOT_W-1:0]] = code; vals[n[SLOT_W-1:0]] = VAL_RELEASE;
                            n = n + 1'b1;
                            flags_next.space_with_other = 1'b0;
                        end
                    end else begin
                        if (flags_reg.modifier_with_other) begin
                            codes[n[SLOT_W-1:0]] = code; vals[n[SLOT_W-1:0]] = VAL_RELEASE;
                            n = n + 1'b1;
                            flags_next.modifier_with_other = 1'b0;
                        end
                        flags_next.modifier_grabbed = 1'b0;
                    end
                    if (!flags_next.space_grabbed && !flags_next.modifier_grabbed) begin
                        flags_next.chord_active = 1'b0;
                    end
                end else if (flags_reg.space_grabbed && is_sp) begin
                    // Lone space tap is replayed as press and release.
                    if (flags_reg.space_with_other) begin
                        codes[0] = code; vals[0] = VAL_RELEASE;
                        n = CNT_W'(1);
                        flags_next.space_with_other = 1'b0;
                    end else begin
                        codes[0] = code; vals[0] = VAL_PRESS;
                        codes[1] = code; vals[1] = VAL_RELEASE;
                        n = CNT_W'(2);
                    end
                    flags_next.space_grabbed = 1'b0;
                end else if (flags_reg.modifier_grabbed) begin
                    if (flags_reg.modifier_with_other) begin
                        codes[0] = code; vals[0] = VAL_RELEASE;
                        n = CNT_W'(1);
                        flags_next.modifier_with_other = 1'b0;
                    end else begin
                        codes[0] = code; vals[0] = VAL_PRESS;
                        codes[1] = code; vals[1] = VAL_RELEASE;
                        n = CNT_W'(2);
                    end
                    flags_next.modifier_grabbed = 1'b0;
                end
            end
        end else if (flags_reg.modifier_grabbed && !flags_reg.space_grabbed && is_key
                     && val == VAL_PRESS) begin
            // Another key under a lone modifier replays the modifier.
            pending_next = code;
            codes[0] = mod16; vals[0] = VAL_PRESS;
            codes[1] = mod16; vals[1] = VAL_HOLD;
            codes[2] = code;  vals[2] = VAL_PRESS;
            n = CNT_W'(3);
            flags_next.modifier_with_other = 1'b1;
        end else if (!flags_reg.modifier_grabbed && flags_reg.space_grabbed && is_key
                     && val == VAL_PRESS) begin
            // Another key under a lone space replays the space press.
            codes[0] = CODE_SPACE; vals[0] = VAL_PRESS;
            codes[1] = code;       vals[1] = VAL_PRESS;
            n = CNT_W'(2);
            flags_next.space_with_other = 1'b1;
        end else if (!flags_reg.modifier_grabbed && flags_reg.space_grabbed && is_key
                     && val == VAL_RELEASE && !flags_reg.space_with_other) begin
            codes[0] = CODE_SPACE; vals[0] = VAL_PRESS;
            codes[1] = code;       vals[1] = VAL_RELEASE;
            n = CNT_W'(2);
        end else begin
            // Everything else passes through unchanged.
            codes[0] = code; vals[0] = val;
            n = CNT_W'(1);
        end
    end

    // Job record and handshakes; items without events are dropped here.
    always_comb begin
        job.ev_type = s_data.event_type;
        job.seconds = s_data.time_seconds;
        job.micros  = s_data.time_micros;
        job.beats   = n;
        job.code    = codes;
        job.value   = vals;
    end
    assign s_ready   = job_ready;
    assign job_valid = s_valid && (n != '0);
    assign accept    = s_valid && s_ready;

    // Chord state updates on each accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg   <= '0;
            pending_reg <= '0;
        end else if (accept) begin
            flags_reg   <= flags_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ===== rtl/kcr_queue.sv =====
// ----------------------------------------------------------------------------
// kcr_queue: job queue
// A short first-in first-out buffer that decouples the classifier from the
// event sequencer.
// ----------------------------------------------------------------------------
module kcr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  kcr_pkg::kcr_job_t in_job,
    output logic              out_valid,
    input  logic              out_ready,
    output kcr_pkg::kcr_job_t out_job
);
    import kcr_pkg::*;

    kcr_job_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/kcr_back.sv =====
// ----------------------------------------------------------------------------
// kcr_back: event sequencer
// Takes one job at a time from the queue and sends its events as result
// beats, one per cycle while m_ready is high, marking the final one.
// ----------------------------------------------------------------------------
module kcr_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  kcr_pkg::kcr_job_t job,
    output logic              m_valid,
    input  logic              m_ready,
    output kcr_pkg::kcr_out_t m_data
);
    import kcr_pkg::*;

    kcr_job_t          entry_reg;
    logic              busy_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              last_beat, beat_done, load;

    assign last_beat = ((CNT_W'(idx_reg) + 1'b1) == entry_reg.beats);
    assign beat_done = busy_reg && m_ready && last_beat;
    assign job_ready = !busy_reg || beat_done;
    assign load      = job_valid && job_ready;

    // Result beat from the held job.
    assign m_valid = busy_reg;
    always_comb begin
        m_data.out_type    = entry_reg.ev_type;
        m_data.out_code    = entry_reg.code[idx_reg];
        m_data.out_value   = entry_reg.value[idx_reg];
        m_data.out_seconds = entry_reg.seconds;
        m_data.out_micros  = entry_reg.micros;
        m_data.last        = last_beat;
    end

    // Job payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            entry_reg <= job;
        end
    end

    // Sequencer control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (beat_done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg && m_ready) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

// ===== rtl/kcr_checker.sv =====
// ----------------------------------------------------------------------------
// kcr_checker: port checker for the key chord remapper
// Watches the top-level ports and flags handshake and reset slips.
// ----------------------------------------------------------------------------
module kcr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input kcr_pkg::kcr_out_t           m_data,
    input logic                        pready
);
    import kcr_pkg::*;

    // A stalled result beat stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    // Reset leaves no result beat pending.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat offered right after reset");

    // Reset leaves the input side ready for a beat.
    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    // The register port never inserts wait states.
    assert property (@(posedge aclk) pready)
        else $error("pready dropped");

endmodule

bind key_chord_remapper kcr_checker u_kcr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

// ===== dv/key_chord_checker.sv =====
// ----------------------------------------------------------------------------
// key_chord_checker: result checker for the key chord remapper
// Watches the input, result and register ports. It keeps its own copy of the
// chord state and the two key registers, works out the events that each
// accepted input beat must produce, and compares every result beat, field by
// field, with the oldest event still due. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module key_chord_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  kcr_pkg::kcr_in_t            s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  kcr_pkg::kcr_out_t           m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [kcr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output int                          fail_count,
    output int                          pending_beats
);
    import kcr_pkg::*;

    localparam int MAX_PRINTED = 40;

    // Register copies.
    logic [9:0]  modifier_code;
    logic [9:0]  target_code;

    // Chord state.
    logic        space_held;
    logic        modifier_held;
    logic        modifier_replayed;
    logic        space_replayed;
    logic        chord_on;
    logic [15:0] pending_code;

    // Events still owed by the block, oldest first.
    kcr_out_t    due_events[$];
    kcr_in_t     cur_item;
    int          emitted;

    // Prints one line per mismatch, up to a limit, and counts every one.
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    // Appends one event stamped with the current item's type and timestamp.
    function automatic void add_event(logic [15:0] code, logic [31:0] value);
        kcr_out_t ev;
        if (emitted >= MAX_BEATS) return;
        ev.out_type    = cur_item.event_type;
        ev.out_code    = code;
        ev.out_value   = value;
        ev.out_seconds = cur_item.time_seconds;
        ev.out_micros  = cur_item.time_micros;
        ev.last        = 1'b0;
        due_events.push_back(ev);
        emitted++;
    endfunction

    // Both keys are down: press and hold the target, replaying the modifier
    // release and the pending key when the modifier was already in use.
    function automatic void start_chord(logic replay);
        if (replay) add_event({6'd0, modifier_code}, VAL_RELEASE);
        chord_on = 1'b1;
        add_event({6'd0, target_code}, VAL_PRESS);
        add_event({6'd0, target_code}, VAL_HOLD);
        if (replay) add_event(pending_code, VAL_PRESS);
    endfunction

    // Works out the events for one accepted input beat and queues them.
    function automatic void remap_event(kcr_in_t item);
        logic        is_key;
        logic [15:0] code;
        logic [31:0] value;
        logic [15:0] mod16;
        logic [15:0] tgt16;
        kcr_out_t    tail;
        cur_item = item;
        emitted  = 0;
        is_key   = (item.event_type == EV_KEY);
        code     = item.event_code;
        value    = item.event_value;
        mod16    = {6'd0, modifier_code};
        tgt16    = {6'd0, target_code};

        if (is_key && (code == CODE_SPACE || code == mod16)) begin
            // Space rules come first, so a modifier set to space acts as space.
            if (!space_held && code == CODE_SPACE && value == VAL_PRESS) begin
                space_held = 1'b1;
                if (modifier_held) start_chord(modifier_replayed);
            end else if (!modifier_held && code == mod16 && value == VAL_PRESS) begin
                modifier_held = 1'b1;
                if (space_held) start_chord(1'b0);
            end else if (space_held && modifier_held && value == VAL_HOLD) begin
                add_event(modifier_replayed ? pending_code : tgt16, VAL_HOLD);
            end else if (value == VAL_HOLD) begin
                add_event(code, VAL_PRESS);
                add_event(code, VAL_HOLD);
            end else if (value == VAL_RELEASE) begin
                if (chord_on) begin
                    add_event(tgt16, VAL_RELEASE);
                    if (code == CODE_SPACE) begin
                        space_held = 1'b0;
                        if (space_replayed) begin
                            add_event(code, VAL_RELEASE);
                            space_replayed = 1'b0;
                        end
                    end else begin
                        if (modifier_replayed) begin
                            add_event(code, VAL_RELEASE);
                            modifier_replayed = 1'b0;
                        end
                        modifier_held = 1'b0;
                    end
                    if (!space_held && !modifier_held) chord_on = 1'b0;
                end else if (space_held && code == CODE_SPACE) begin
                    if (space_replayed) begin
                        add_event(code, VAL_RELEASE);
                        space_replayed = 1'b0;
                    end else begin
                        add_event(code, VAL_PRESS);
                        add_event(code, VAL_RELEASE);
                    end
                    space_held = 1'b0;
                end else if (modifier_held) begin
                    if (modifier_replayed) begin
                        add_event(code, VAL_RELEASE);
                        modifier_replayed = 1'b0;
                    end else begin
                        add_event(code, VAL_PRESS);
                        add_event(code, VAL_RELEASE);
                    end
                    modifier_held = 1'b0;
                end
            end
            // Repeated presses and other values of a held key vanish.
        end else if (modifier_held && !space_held && is_key && value == VAL_PRESS) begin
            // Another key joins the lone modifier: replay it as a plain key.
            pending_code = code;
            add_event(mod16, VAL_PRESS);
            add_event(mod16, VAL_HOLD);
            add_event(code, VAL_PRESS);
            modifier_replayed = 1'b1;
        end else if (!modifier_held && space_held && is_key && value == VAL_PRESS) begin
            add_event(CODE_SPACE, VAL_PRESS);
            add_event(code, VAL_PRESS);
            space_replayed = 1'b1;
        end else if (!modifier_held && space_held && is_key && value == VAL_RELEASE
                     && !space_replayed) begin
            add_event(CODE_SPACE, VAL_PRESS);
            add_event(code, VAL_RELEASE);
        end else begin
            add_event(code, value);
        end

        // The final event of the item carries last.
        if (emitted > 0) begin
            tail      = due_events.pop_back();
            tail.last = 1'b1;
            due_events.push_back(tail);
        end
    endfunction

    // Compares one result beat with the oldest event due.
    task automatic check_beat(input kcr_out_t got);
        kcr_out_t want;
        if (due_events.size() == 0) begin
            report_mismatch($sformatf("result beat code %0d with nothing due", got.out_code));
            return;
        end
        want = due_events.pop_front();
        if (got.out_type !== want.out_type)
            report_mismatch($sformatf("out_type %h, expected %h", got.out_type, want.out_type));
        if (got.out_code !== want.out_code)
            report_mismatch($sformatf("out_code %0d, expected %0d",
                                      got.out_code, want.out_code));
        if (got.out_value !== want.out_value)
            report_mismatch($sformatf("out_value %h, expected %h",
                                      got.out_value, want.out_value));
        if (got.out_seconds !== want.out_seconds)
            report_mismatch($sformatf("out_seconds %h, expected %h",
                                      got.out_seconds, want.out_seconds));
        if (got.out_micros !== want.out_micros)
            report_mismatch($sformatf("out_micros %0d, expected %0d",
                                      got.out_micros, want.out_micros));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b on code %0d",
                                      got.last, want.last, want.out_code));
    endtask

    // Sample all ports at the rising edge: register writes, then input beats,
    // then result beats.
    always @(posedge aclk) begin
        if (!aresetn) begin
            modifier_code     = CODE_RALT;
            target_code       = TARGET_RESET;
            space_held        = 1'b0;
            modifier_held     = 1'b0;
            modifier_replayed = 1'b0;
            space_replayed    = 1'b0;
            chord_on          = 1'b0;
            pending_code      = '0;
            fail_count        = 0;
            due_events.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if ((paddr >> 2) == REG_MODIFIER)
                    modifier_code = pwdata[9:0];
                else if ((paddr >> 2) == REG_TARGET)
                    target_code = pwdata[9:0];
            end
            if (s_valid && s_ready) remap_event(s_data);
            if (m_valid && m_ready) check_beat(m_data);
        end
        pending_beats = due_events.size();
    end

endmodule

// ===== dv/tb_key_chord_remapper.sv =====
// ----------------------------------------------------------------------------
// tb_key_chord_remapper: testbench top for the key chord remapper
// Drives key event beats and register writes into the block and gives the
// verdict. A directed run covers taps, holds, chords and replays; random
// phases then play chord sequences with random content and noise beats under
// several key mappings and idle patterns, including a long result stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_key_chord_remapper;
    import kcr_pkg::*;

    localparam logic [9:0]  CODE_RMETA    = 10'd126;
    localparam logic [15:0] RALT16        = {6'd0, CODE_RALT};
    localparam int          LONG_HOLD     = 150;
    localparam int          NUM_PHASES    = 5;
    localparam int          ITEM_GOAL     = 470;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    kcr_in_t             s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    kcr_out_t            m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    int                  fail_count;
    int                  pending_beats;

    // Idle control shared with the ready process.
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  hold_requests  = 0;
    int                  hold_seen      = 0;
    int                  hold_left      = 0;

    int                  items_sent     = 0;
    logic [9:0]          cur_modifier   = CODE_RALT;

    always #10 aclk = ~aclk;

    key_chord_remapper u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    key_chord_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready   <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hard limit on the run.
    initial begin
        #4_000_000;
        $display("FAIL key_chord_remapper");
        $finish;
    end

    // Offers one beat after a random gap and returns at the falling edge
    // after it was accepted.
    task automatic send_event(input kcr_in_t beat);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    function automatic kcr_in_t make_beat(logic [15:0] ev_type, logic [15:0] code,
                                          logic [31:0] value);
        kcr_in_t beat;
        beat.event_type   = ev_type;
        beat.event_code   = code;
        beat.event_value  = value;
        beat.time_seconds = {$urandom, $urandom};
        beat.time_micros  = 20'($urandom_range(999999));
        return beat;
    endfunction

    task automatic send_key(input logic [15:0] code, input logic [31:0] value);
        send_event(make_beat(EV_KEY, code, value));
    endtask

    // Stops offering beats until every due event has come out.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_beats != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_register(input kcr_reg_t which, input logic [9:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= {22'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] pick_other();
        if ($urandom_range(7) == 0) return 16'($urandom);
        return 16'($urandom_range(1, 130));
    endfunction

    function automatic logic [15:0] pick_code(logic [15:0] other);
        case ($urandom_range(2))
            0:       return CODE_SPACE;
            1:       return {6'd0, cur_modifier};
            default: return other;
        endcase
    endfunction

    // One chord-style sequence with random order, holds and releases.
    task automatic chord_burst();
        logic [15:0] other;
        logic [15:0] mod16;
        int          holds;
        other = pick_other();
        mod16 = {6'd0, cur_modifier};
        holds = $urandom_range(3);
        case ($urandom_range(4))
            0: begin
                send_key(mod16, VAL_PRESS);
                send_key(CODE_SPACE, VAL_PRESS);
            end
            1: begin
                send_key(CODE_SPACE, VAL_PRESS);
                send_key(mod16, VAL_PRESS);
            end
            2: begin
                // Modifier used as a plain key first, then joined by space.
                send_key(mod16, VAL_PRESS);
                send_key(other, VAL_PRESS);
                send_key(CODE_SPACE, VAL_PRESS);
            end
            3: begin
                send_key(CODE_SPACE, VAL_PRESS);
                send_key(other, $urandom_range(1) ? VAL_PRESS : VAL_RELEASE);
            end
            default: begin
                send_key($urandom_range(1) ? CODE_SPACE : mod16, VAL_PRESS);
            end
        endcase
        repeat (holds) send_key(pick_code(other), ($urandom_range(4) == 0) ? VAL_PRESS : VAL_HOLD);
        if ($urandom_range(2) == 0) send_key(other, VAL_RELEASE);
        if ($urandom_range(1)) begin
            send_key(CODE_SPACE, VAL_RELEASE);
            send_key(mod16, VAL_RELEASE);
        end else begin
            send_key(mod16, VAL_RELEASE);
            send_key(CODE_SPACE, VAL_RELEASE);
        end
    endtask

    // Beats with random type, code and value, some of them key events.
    task automatic noise_burst();
        logic [15:0] ev_type;
        logic [15:0] code;
        logic [31:0] value;
        repeat ($urandom_range(1, 3)) begin
            ev_type = $urandom_range(1) ? EV_KEY : 16'($urandom);
            code    = ($urandom_range(2) == 0) ? 16'($urandom) : pick_code(pick_other());
            value   = $urandom_range(1) ? $urandom : 32'($urandom_range(3));
            send_event(make_beat(ev_type, code, value));
        end
    endtask

    initial begin
        logic [9:0] phase_modifier [NUM_PHASES];
        logic [9:0] phase_target   [NUM_PHASES];
        int         phase_send     [NUM_PHASES];
        int         phase_stall    [NUM_PHASES];
        kcr_in_t    beat;
        int         goal;
        int         waited;

        phase_modifier = '{CODE_RALT, CODE_RMETA, 10'd0, 10'd767, CODE_SPACE[9:0]};
        phase_target   = '{TARGET_RESET, 10'd767, 10'd0, CODE_SPACE[9:0], 10'd1};
        phase_send     = '{0, 65, 0, 37, 0};
        phase_stall    = '{0, 0, 65, 37, 0};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under the reset mapping.
        // Non-key beats at the extremes of every field, and a key beat with an odd value, pass through.
        beat = '{event_type: 16'd0, event_code: 16'd0, event_value: 32'd0,
                 time_seconds: 64'h8000_0000_0000_0000, time_micros: 20'd0};
        send_event(beat);
        beat = '{event_type: 16'hFFFF, event_code: 16'hFFFF, event_value: 32'h7FFF_FFFF,
                 time_seconds: 64'h7FFF_FFFF_FFFF_FFFF, time_micros: 20'd999999};
        send_event(beat);
        send_key(16'd30, 32'h8000_0000);
        // Space tapped alone comes out as press and release.
        send_key(CODE_SPACE, VAL_PRESS);
        send_key(CODE_SPACE, VAL_RELEASE);
        // Lone modifier: autorepeat, a repeated press that vanishes, release.
        send_key(RALT16, VAL_PRESS);
        send_key(RALT16, VAL_HOLD);
        send_key(RALT16, VAL_PRESS);
        send_key(RALT16, VAL_RELEASE);
        // Plain chord: target pressed, held, then released with each key.
        send_key(RALT16, VAL_PRESS);
        send_key(CODE_SPACE, VAL_PRESS);
        send_key(CODE_SPACE, VAL_HOLD);
        send_key(RALT16, VAL_RELEASE);
        send_key(CODE_SPACE, VAL_RELEASE);
        // Modifier replayed for another key, then space turns it into a chord.
        send_key(RALT16, VAL_PRESS);
        send_key(16'd30, VAL_PRESS);
        send_key(CODE_SPACE, VAL_PRESS);
        send_key(CODE_SPACE, VAL_HOLD);
        send_key(CODE_SPACE, VAL_RELEASE);
        send_key(RALT16, VAL_RELEASE);
        // Space replayed for another key press.
        send_key(CODE_SPACE, VAL_PRESS);
        send_key(16'd31, VAL_PRESS);
        send_key(CODE_SPACE, VAL_RELEASE);
        // Release of another key while space is held back.
        send_key(CODE_SPACE, VAL_PRESS);
        send_key(16'd32, VAL_RELEASE);
        send_key(CODE_SPACE, VAL_RELEASE);

        // Random phases, each with its own mapping and idle pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_register(REG_MODIFIER, phase_modifier[p]);
            write_register(REG_TARGET, phase_target[p]);
            cur_modifier   = phase_modifier[p];
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_stall[p];
            if (p == 0) begin
                // Long result stall while beats keep coming, to fill the block.
                hold_requests++;
                repeat (4) chord_burst();
            end
            goal = 26 + (p + 1) * (ITEM_GOAL - 26) / NUM_PHASES;
            while (items_sent < goal) begin
                if ($urandom_range(2) == 0)
                    noise_burst();
                else
                    chord_burst();
            end
        end

        // Drain, with a bound, and settle.
        s_valid <= 1'b0;
        waited = 0;
        while (pending_beats != 0 && waited < 5000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (10) @(negedge aclk);
        if (fail_count == 0 && pending_beats == 0) begin
            $display("PASS key_chord_remapper");
        end else begin
            $display("FAIL key_chord_remapper");
        end
        $finish;
    end

endmodule
